FILE: sv/mpool_pkg.sv
// shared types, constants and register codes of the 3x3 stride-2 max pooling block
package mpool_pkg;

  // default parameter values
  localparam int DATA_WIDTH_DEF = 16;
  localparam int MAX_COLS_DEF   = 256;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  // register field widths
  localparam int ROWS_W     = 11;
  localparam int COLS_CFG_W = 9;
  localparam int CHANS_W    = 11;

  // effective column count, wide enough for the largest MAX_COLS
  localparam int COLS_W = 13;

  // position counters
  localparam int ROW_CNT_W  = 10;
  localparam int CHAN_CNT_W = 10;

  // size limits
  localparam logic [ROWS_W-1:0]  MAX_ROWS  = 11'd1024;
  localparam logic [CHANS_W-1:0] MAX_CHANS = 11'd1024;

  // register reset values
  localparam logic [ROWS_W-1:0]     IN_ROWS_RST      = 11'd32;
  localparam logic [COLS_CFG_W-1:0] IN_COLS_RST      = 9'd32;
  localparam logic [CHANS_W-1:0]    NUM_CHANNELS_RST = 11'd16;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IN_ROWS      = 2'd0,
    REG_IN_COLS      = 2'd1,
    REG_NUM_CHANNELS = 2'd2
  } cfg_reg_e;

  // effective plane geometry
  typedef struct packed {
    logic [ROWS_W-1:0]  rows;
    logic [COLS_W-1:0]  cols;
    logic [CHANS_W-1:0] chans;
  } sizes_t;

  // per-pixel control handed from the front end to the vertical stage
  typedef struct packed {
    logic have_h;    // a row maximum for one output column is ready
    logic odd_row;   // odd input row: read-modify-write of the band entry
    logic read_en;   // band entry must be read
    logic rd_bank;   // bank that is read
    logic wr_bank;   // bank that is written
    logic emit;      // this pixel closes a window
    logic map_end;   // last window of the whole map
  } row_ctrl_t;

endpackage

FILE: sv/mpool_if.sv
// stream and configuration interfaces of the max pooling block
interface mpool_pix_if #(
  parameter int DATA_WIDTH = mpool_pkg::DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink   (input valid, input pixel_value, output ready);
endinterface

interface mpool_res_if #(
  parameter int DATA_WIDTH = mpool_pkg::DATA_WIDTH_DEF
);
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-2:0] pooled_value;
  logic                  map_end;

  modport source (output valid, output pooled_value, output map_end, input ready);
  modport sink   (input valid, input pooled_value, input map_end, output ready);
endinterface

interface mpool_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [mpool_pkg::CFG_IDX_W-1:0]  index;
  logic [mpool_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: sv/mpool_cfg_regs.sv
// configuration registers and effective plane sizes
module mpool_cfg_regs #(
  parameter int MAX_COLS = mpool_pkg::MAX_COLS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  mpool_cfg_if.sink         cfg_i,
  output mpool_pkg::sizes_t sizes_o
);
  import mpool_pkg::*;

  localparam logic [COLS_W-1:0] COLS_LIM = COLS_W'(MAX_COLS);

  logic [ROWS_W-1:0]     in_rows_q;
  logic [COLS_CFG_W-1:0] in_cols_q;
  logic [CHANS_W-1:0]    num_channels_q;
  logic                  wr_en;

  logic [ROWS_W-1:0]  rows_even;
  logic [COLS_W-1:0]  cols_even;

  // writes are always taken
  assign cfg_i.ready = 1'b1;
  assign wr_en       = cfg_i.valid && cfg_i.ready;

  // register file, unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_rows_q      <= IN_ROWS_RST;
      in_cols_q      <= IN_COLS_RST;
      num_channels_q <= NUM_CHANNELS_RST;
    end else if (wr_en) begin
      case (cfg_i.index)
        REG_IN_ROWS:      in_rows_q      <= cfg_i.data[ROWS_W-1:0];
        REG_IN_COLS:      in_cols_q      <= cfg_i.data[COLS_CFG_W-1:0];
        REG_NUM_CHANNELS: num_channels_q <= cfg_i.data[CHANS_W-1:0];
        default: ;
      endcase
    end
  end

  // drop the low bit of the row and column sizes and saturate all sizes to the legal ranges
  assign rows_even = {in_rows_q[ROWS_W-1:1], 1'b0};
  assign cols_even = {{(COLS_W-COLS_CFG_W){1'b0}}, in_cols_q[COLS_CFG_W-1:1], 1'b0};

  always_comb begin
    if (rows_even < ROWS_W'(2))  sizes_o.rows = ROWS_W'(2);
    else if (rows_even > MAX_ROWS) sizes_o.rows = MAX_ROWS;
    else                         sizes_o.rows = rows_even;

    if (cols_even < COLS_W'(2))  sizes_o.cols = COLS_W'(2);
    else if (cols_even > COLS_LIM) sizes_o.cols = COLS_LIM;
    else                         sizes_o.cols = cols_even;

    if (num_channels_q < CHANS_W'(1))    sizes_o.chans = CHANS_W'(1);
    else if (num_channels_q > MAX_CHANS) sizes_o.chans = MAX_CHANS;
    else                                 sizes_o.chans = num_channels_q;
  end

endmodule

FILE: sv/mpool_front.sv
// position counters and horizontal running maximum, one pixel per accepted transaction
module mpool_front #(
  parameter int DATA_WIDTH = mpool_pkg::DATA_WIDTH_DEF,
  parameter int MAX_COLS   = mpool_pkg::MAX_COLS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           accept_i,
  input  logic signed [DATA_WIDTH-1:0]   pixel_i,
  input  mpool_pkg::sizes_t              sizes_i,
  output mpool_pkg::row_ctrl_t           ctrl_o,
  output logic [DATA_WIDTH-2:0]          hval_o,
  output logic [$clog2(MAX_COLS/2)-1:0]  oc_o
);
  import mpool_pkg::*;

  localparam int CW   = $clog2(MAX_COLS);
  localparam int OC_W = $clog2(MAX_COLS/2);
  localparam int PW   = DATA_WIDTH - 1;
  localparam logic [CW-1:0] BANK_DEPTH = CW'(MAX_COLS/2);

  logic [ROW_CNT_W-1:0]  row_count_q, row_count_d;
  logic [CW-1:0]         col_count_q, col_count_d;
  logic [CHAN_CNT_W-1:0] chan_count_q, chan_count_d;
  logic [PW-1:0]         horiz_run_max_q, horiz_run_max_d;

  logic [ROW_CNT_W-1:0]  r;
  logic [CW-1:0]         c;
  logic [CHAN_CNT_W-1:0] ch;
  logic                  last_row, last_col, last_chan;
  logic [PW-1:0]         px;
  logic [PW-1:0]         run_px_max;
  logic                  have_h;
  logic [CW-1:0]         oc_full;

  // positions restart when they sit at or beyond the current size
  always_comb begin
    r  = (({1'b0, row_count_q} >= sizes_i.rows)) ? '0 : row_count_q;
    c  = (({{(COLS_W-CW){1'b0}}, col_count_q} >= sizes_i.cols)) ? '0 : col_count_q;
    ch = (({1'b0, chan_count_q} >= sizes_i.chans)) ? '0 : chan_count_q;
  end

  assign last_row  = ({1'b0, r} == sizes_i.rows - ROWS_W'(1));
  assign last_col  = ({{(COLS_W-CW){1'b0}}, c} == sizes_i.cols - COLS_W'(1));
  assign last_chan = ({1'b0, ch} == sizes_i.chans - CHANS_W'(1));

  // negative samples count as zero
  assign px         = pixel_i[DATA_WIDTH-1] ? '0 : pixel_i[PW-1:0];
  assign run_px_max = (horiz_run_max_q > px) ? horiz_run_max_q : px;

  // horizontal stage: one row maximum per output column
  always_comb begin
    horiz_run_max_d = horiz_run_max_q;
    hval_o          = '0;
    have_h          = 1'b0;
    if (c == '0) begin
      horiz_run_max_d = px;
    end else if (!c[0]) begin
      hval_o          = run_px_max;
      have_h          = 1'b1;
      horiz_run_max_d = px;
    end else begin
      horiz_run_max_d = run_px_max;
      if (last_col) begin
        hval_o = run_px_max;
        have_h = 1'b1;
      end
    end
  end

  // output column and band addressing
  always_comb begin
    oc_full = last_col ? (c >> 1) : ((c >> 1) - CW'(1));
    if (oc_full >= BANK_DEPTH) oc_full = '0;
  end
  assign oc_o = oc_full[OC_W-1:0];

  always_comb begin
    ctrl_o.have_h  = have_h;
    ctrl_o.odd_row = r[0];
    ctrl_o.read_en = have_h && (r != '0);
    ctrl_o.rd_bank = r[0] ? r[1] : !r[1];
    ctrl_o.wr_bank = r[1];
    ctrl_o.emit    = have_h && (r != '0) && (!r[0] || last_row);
    ctrl_o.map_end = last_row && last_col && last_chan;
  end

  // position advance
  always_comb begin
    row_count_d  = r;
    col_count_d  = c + CW'(1);
    chan_count_d = ch;
    if (last_col) begin
      col_count_d = '0;
      if (last_row) begin
        row_count_d  = '0;
        chan_count_d = last_chan ? '0 : ch + CHAN_CNT_W'(1);
      end else begin
        row_count_d = r + ROW_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q     <= '0;
      col_count_q     <= '0;
      chan_count_q    <= '0;
      horiz_run_max_q <= '0;
    end else if (accept_i) begin
      row_count_q     <= row_count_d;
      col_count_q     <= col_count_d;
      chan_count_q    <= chan_count_d;
      horiz_run_max_q <= horiz_run_max_d;
    end
  end

endmodule

FILE: sv/mpool_bank_mem.sv
// band memory of per-column partial maxima, one read and one write port
module mpool_bank_mem #(
  parameter int ADDR_W = 8,
  parameter int DATA_W = 15
) (
  input  logic              clk_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [DATA_W-1:0] rd_data_o,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [DATA_W-1:0] wr_data_i
);

  logic [DATA_W-1:0] mem_q [2**ADDR_W];

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port, holds its data between reads
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

FILE: sv/max_pool_3x3_stride2_core.sv
// top level of the streaming 3x3 stride-2 max pooling block
// Takes one pixel per clock, with no bubbles between transactions, while each result is
// taken as it comes; a pooled result passes from the compare stage register into the
// output register, waiting in the compare stage while an earlier result waits to be
// taken. The rate is set by the band memory, which needs no clearing pass after reset
// and sees one registered read at pixel acceptance and one write when the pixel leaves
// the compare stage; an output register with its own valid lets a new pixel enter the
// empty compare stage while a result waits to be taken. Sizes are taken from the configuration
// registers, which the user must write only while no result is pending; the block does not enforce it.
module max_pool_3x3_stride2_core #(
  parameter int DATA_WIDTH = mpool_pkg::DATA_WIDTH_DEF,
  parameter int MAX_COLS   = mpool_pkg::MAX_COLS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mpool_pix_if.sink   pix_i,
  mpool_res_if.source pool_o,
  mpool_cfg_if.sink   cfg_i
);
  import mpool_pkg::*;

  localparam int OC_W = $clog2(MAX_COLS/2);
  localparam int AW   = OC_W + 1;
  localparam int PW   = DATA_WIDTH - 1;

  sizes_t        sizes;
  row_ctrl_t     fe_ctrl;
  logic [PW-1:0] fe_hval;
  logic [OC_W-1:0] fe_oc;

  logic accept, ready_out, s1_leave;

  logic            s1_valid_q;
  row_ctrl_t       s1_ctrl_q;
  logic [PW-1:0]   s1_hval_q;
  logic [OC_W-1:0] s1_oc_q;

  logic [PW-1:0] band_rdata;
  logic [PW-1:0] vert_max;
  logic [PW-1:0] wr_data;

  logic          out_valid_q;
  logic [PW-1:0] out_value_q;
  logic          out_end_q;

  // handshake: the compare stage moves on when it is empty or the output frees up
  assign ready_out   = !out_valid_q || pool_o.ready;
  assign pix_i.ready = !s1_valid_q || ready_out;
  assign accept      = pix_i.valid && pix_i.ready;
  assign s1_leave    = s1_valid_q && ready_out;

  mpool_cfg_regs #(
    .MAX_COLS (MAX_COLS)
  ) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_i),
    .sizes_o (sizes)
  );

  mpool_front #(
    .DATA_WIDTH (DATA_WIDTH),
    .MAX_COLS   (MAX_COLS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .pixel_i  (pix_i.pixel_value),
    .sizes_i  (sizes),
    .ctrl_o   (fe_ctrl),
    .hval_o   (fe_hval),
    .oc_o     (fe_oc)
  );

  // band memory: read on acceptance, write when the pixel leaves the compare stage
  mpool_bank_mem #(
    .ADDR_W (AW),
    .DATA_W (PW)
  ) u_band (
    .clk_i     (clk_i),
    .rd_en_i   (accept && fe_ctrl.read_en),
    .rd_addr_i ({fe_ctrl.rd_bank, fe_oc}),
    .rd_data_o (band_rdata),
    .wr_en_i   (s1_leave && s1_ctrl_q.have_h),
    .wr_addr_i ({s1_ctrl_q.wr_bank, s1_oc_q}),
    .wr_data_i (wr_data)
  );

  // compare stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_ctrl_q  <= '0;
    end else if (pix_i.ready) begin
      s1_valid_q <= accept;
      if (accept) begin
        s1_ctrl_q <= fe_ctrl;
      end
    end
  end

  // compare stage payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_hval_q <= fe_hval;
      s1_oc_q   <= fe_oc;
    end
  end

  // vertical combine of the stored partial maximum and the new row maximum
  assign vert_max = (band_rdata > s1_hval_q) ? band_rdata : s1_hval_q;
  assign wr_data  = s1_ctrl_q.odd_row ? vert_max : s1_hval_q;

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ready_out) begin
      out_valid_q <= s1_valid_q && s1_ctrl_q.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_leave && s1_ctrl_q.emit) begin
      out_value_q <= vert_max;
      out_end_q   <= s1_ctrl_q.map_end;
    end
  end

  assign pool_o.valid        = out_valid_q;
  assign pool_o.pooled_value = out_value_q;
  assign pool_o.map_end      = out_end_q;

  // a closing window always carries a row maximum
  a_emit_has_row_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_ctrl_q.emit |-> s1_ctrl_q.have_h)
    else $error("window closes without a row maximum");

  // an empty compare stage never blocks the input
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> pix_i.ready)
    else $error("input stalled with an empty compare stage");

  // a result leaving the compare stage shows up on the output
  a_result_delivered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_leave && s1_ctrl_q.emit |=> out_valid_q)
    else $error("result lost between compare stage and output");

  // the final flag only rides on a closing window
  a_map_end_on_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_ctrl_q.map_end |-> s1_ctrl_q.emit)
    else $error("map end flag without a result");

endmodule
